// File: rtl/fixed_to_decimal_ascii_top_assert.svh
// Assertion macros for the fixed-to-decimal text formatter checker.
`ifndef FIXED_TO_DECIMAL_ASCII_TOP_ASSERT_SVH
`define FIXED_TO_DECIMAL_ASCII_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define FDA_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define FDA_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/fda_pkg.sv
// Shared types, constants and tables of the fixed-to-decimal text formatter.
`default_nettype none

package fda_pkg;

  localparam int BIN_W      = 40;  // binary width of integer part and scaled fraction
  localparam int NUM_DIGITS = 13;  // BCD digits that hold any BIN_W value
  localparam int BCD_W      = 4 * NUM_DIGITS;
  localparam int DIG_IDX_W  = 4;
  localparam int MAX_CHARS  = 22;
  localparam int CHAR_CNT_W = 5;
  localparam int FRAC_CAP   = 12;
  localparam int N_CAP      = 19;
  localparam int N_W        = 5;
  localparam int FRAC_W     = 4;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SCALE,
    ST_ROUND,
    ST_CARRY,
    ST_CONVERT,
    ST_PREP,
    ST_SIGN,
    ST_INT,
    ST_DOT,
    ST_FRAC
  } state_e;

  typedef enum logic [1:0] {
    SEL_SIGN,
    SEL_INT,
    SEL_DOT,
    SEL_FRAC
  } char_sel_e;

  typedef struct packed {
    logic      load;
    logic      search_step;
    logic      scale_step;
    logic      round;
    logic      carry;
    logic      conv_step;
    logic      prep;
    logic      emit;
    char_sel_e sel;
  } cmd_t;

  typedef struct packed {
    logic search_hit;
    logic scale_done;
    logic conv_done;
    logic neg;
    logic ptr_zero;
    logic slot_free;
    logic last;
  } sts_t;

  function automatic logic [63:0] pow10(input logic [N_W-1:0] idx);
    logic [63:0] r;
    unique case (idx)
      5'd0:    r = 64'd1;
      5'd1:    r = 64'd10;
      5'd2:    r = 64'd100;
      5'd3:    r = 64'd1000;
      5'd4:    r = 64'd10000;
      5'd5:    r = 64'd100000;
      5'd6:    r = 64'd1000000;
      5'd7:    r = 64'd10000000;
      5'd8:    r = 64'd100000000;
      5'd9:    r = 64'd1000000000;
      5'd10:   r = 64'd10000000000;
      5'd11:   r = 64'd100000000000;
      5'd12:   r = 64'd1000000000000;
      5'd13:   r = 64'd10000000000000;
      5'd14:   r = 64'd100000000000000;
      5'd15:   r = 64'd1000000000000000;
      5'd16:   r = 64'd10000000000000000;
      5'd17:   r = 64'd100000000000000000;
      5'd18:   r = 64'd1000000000000000000;
      5'd19:   r = 64'd10000000000000000000;
      default: r = '1;
    endcase
    return r;
  endfunction

  // Add-3 correction of every BCD digit that is 5 or more (double dabble).
  function automatic logic [BCD_W-1:0] dabble_adj(input logic [BCD_W-1:0] bcd);
    logic [BCD_W-1:0] r;
    r = bcd;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        r[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/fda_datapath.sv
// Datapath: magnitude, digit-count search, fraction scaling, BCD conversion, char output.
`default_nettype none

module fda_datapath import fda_pkg::*; #(
  parameter int INT_BITS     = 32,
  parameter int FRAC_BITS    = 32,
  parameter int DIGIT_BUDGET = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [63:0] in_value_i,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_char_o,
  output logic        out_last_o
);

  localparam int TOT_W      = (INT_BITS + FRAC_BITS > 64) ? 64 : INT_BITS + FRAC_BITS;
  localparam int PROD_W     = FRAC_BITS + BIN_W;
  localparam int CONV_CNT_W = $clog2(BIN_W + 1);
  localparam logic [PROD_W:0] HALF = (PROD_W + 1)'(1) << (FRAC_BITS - 1);

  logic                  neg_q;
  logic [BIN_W-1:0]      ip_q;
  logic [PROD_W-1:0]     prod_q;
  logic [BIN_W-1:0]      q_q;
  logic [N_W-1:0]        n_q;
  logic [FRAC_W-1:0]     f_q;
  logic [FRAC_W-1:0]     scale_cnt_q;
  logic [CONV_CNT_W-1:0] conv_cnt_q;
  logic [BCD_W-1:0]      bcd_i_q;
  logic [BCD_W-1:0]      bcd_f_q;
  logic [DIG_IDX_W-1:0]  ptr_q;
  logic [DIG_IDX_W-1:0]  low_q;
  logic                  qnz_q;
  logic [CHAR_CNT_W-1:0] char_cnt_q;
  logic                  out_valid_q;
  logic [7:0]            out_char_q;
  logic                  out_last_q;

  logic [TOT_W-1:0]     v;
  logic [TOT_W-1:0]     mag;
  logic [63:0]          p_n;
  logic [63:0]          p_f;
  logic [63:0]          ip_wide;
  logic                 hit;
  logic [N_W-1:0]       f_wide;
  logic [FRAC_W-1:0]    f_new;
  logic [PROD_W:0]      sum;
  logic [BCD_W-1:0]     adj_i;
  logic [BCD_W-1:0]     adj_f;
  logic [DIG_IDX_W-1:0] msd;
  logic [DIG_IDX_W-1:0] lsd;
  logic [3:0]           dig_i;
  logic [3:0]           dig_f;
  logic                 cap;
  logic                 last;
  logic [7:0]           char_d;
  logic                 slot_free;

  assign v   = in_value_i[TOT_W-1:0];
  assign mag = v[TOT_W-1] ? (TOT_W'(0) - v) : v;

  // Digit-count search: smallest n with magnitude <= 10^n
  assign p_n     = pow10(n_q);
  assign ip_wide = 64'(ip_q);
  assign hit     = (ip_wide < p_n) || ((ip_wide == p_n) && (prod_q == '0)) ||
                   (n_q == N_W'(N_CAP));

  always_comb begin
    if (N_W'(DIGIT_BUDGET) > n_q) begin
      f_wide = N_W'(DIGIT_BUDGET) - n_q;
    end else begin
      f_wide = '0;
    end
    if (f_wide > N_W'(FRAC_CAP)) begin
      f_wide = N_W'(FRAC_CAP);
    end
    f_new = f_wide[FRAC_W-1:0];
  end

  assign p_f   = pow10(N_W'(f_q));
  assign sum   = {1'b0, prod_q} + HALF;
  assign adj_i = dabble_adj(bcd_i_q);
  assign adj_f = dabble_adj(bcd_f_q);

  // Highest nonzero integer digit and lowest nonzero fraction digit
  always_comb begin
    msd = '0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_i_q[4*i +: 4] != 4'd0) msd = DIG_IDX_W'(i);
    end
    lsd = '0;
    for (int i = NUM_DIGITS - 1; i >= 0; i--) begin
      if (bcd_f_q[4*i +: 4] != 4'd0) lsd = DIG_IDX_W'(i);
    end
  end

  assign dig_i = bcd_i_q[{ptr_q, 2'b00} +: 4];
  assign dig_f = bcd_f_q[{ptr_q, 2'b00} +: 4];
  assign cap   = (char_cnt_q == CHAR_CNT_W'(MAX_CHARS - 1));

  always_comb begin
    unique case (cmd_i.sel)
      SEL_SIGN: begin
        char_d = CHAR_MINUS;
        last   = cap;
      end
      SEL_INT: begin
        char_d = CHAR_ZERO + 8'(dig_i);
        last   = cap || ((ptr_q == '0) && !qnz_q);
      end
      SEL_DOT: begin
        char_d = CHAR_DOT;
        last   = cap;
      end
      SEL_FRAC: begin
        char_d = CHAR_ZERO + 8'(dig_f);
        last   = cap || (ptr_q == low_q);
      end
      default: begin
        char_d = CHAR_ZERO;
        last   = 1'b1;
      end
    endcase
  end

  assign slot_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      neg_q  <= v[TOT_W-1];
      ip_q   <= BIN_W'(mag[TOT_W-1:FRAC_BITS]);
      prod_q <= PROD_W'(mag[FRAC_BITS-1:0]);
      n_q    <= '0;
    end
    if (cmd_i.search_step) begin
      if (hit) begin
        f_q         <= f_new;
        scale_cnt_q <= f_new;
      end else begin
        n_q <= n_q + 1'b1;
      end
    end
    if (cmd_i.scale_step) begin
      prod_q      <= (prod_q << 3) + (prod_q << 1);
      scale_cnt_q <= scale_cnt_q - 1'b1;
    end
    if (cmd_i.round) begin
      q_q <= sum[FRAC_BITS +: BIN_W];
    end
    if (cmd_i.carry) begin
      // rounding reached 10^F: carry into the integer part
      if (q_q == p_f[BIN_W-1:0]) begin
        ip_q <= ip_q + 1'b1;
        q_q  <= '0;
      end
      bcd_i_q    <= '0;
      bcd_f_q    <= '0;
      conv_cnt_q <= '0;
    end
    if (cmd_i.conv_step) begin
      bcd_i_q    <= {adj_i[BCD_W-2:0], ip_q[BIN_W-1]};
      bcd_f_q    <= {adj_f[BCD_W-2:0], q_q[BIN_W-1]};
      ip_q       <= {ip_q[BIN_W-2:0], 1'b0};
      q_q        <= {q_q[BIN_W-2:0], 1'b0};
      conv_cnt_q <= conv_cnt_q + 1'b1;
    end
    if (cmd_i.prep) begin
      ptr_q      <= msd;
      low_q      <= lsd;
      qnz_q      <= (bcd_f_q != '0);
      char_cnt_q <= '0;
    end
    if (cmd_i.emit) begin
      char_cnt_q <= char_cnt_q + 1'b1;
      unique case (cmd_i.sel)
        SEL_INT:  ptr_q <= ptr_q - 1'b1;
        SEL_DOT:  ptr_q <= f_q - 1'b1;
        SEL_FRAC: ptr_q <= ptr_q - 1'b1;
        default:  ptr_q <= ptr_q;
      endcase
    end
  end

  // Output register: parts the formatter from the downstream stall
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_char_q <= char_d;
      out_last_q <= last;
    end
  end

  assign sts_o.search_hit = hit;
  assign sts_o.scale_done = (scale_cnt_q == '0);
  assign sts_o.conv_done  = (conv_cnt_q == CONV_CNT_W'(BIN_W));
  assign sts_o.neg        = neg_q;
  assign sts_o.ptr_zero   = (ptr_q == '0);
  assign sts_o.slot_free  = slot_free;
  assign sts_o.last       = last;

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign out_last_o  = out_last_q;

endmodule

`default_nettype wire

// File: rtl/fda_ctrl.sv
// Controller state machine sequencing search, scaling, conversion and char output.
`default_nettype none

module fda_ctrl import fda_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q;
  state_e state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.sel  = SEL_INT;
    in_ready_o = (state_q == ST_IDLE);
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        cmd_o.search_step = 1'b1;
        if (sts_i.search_hit) state_d = ST_SCALE;
      end
      ST_SCALE: begin
        if (sts_i.scale_done) begin
          state_d = ST_ROUND;
        end else begin
          cmd_o.scale_step = 1'b1;
        end
      end
      ST_ROUND: begin
        cmd_o.round = 1'b1;
        state_d     = ST_CARRY;
      end
      ST_CARRY: begin
        cmd_o.carry = 1'b1;
        state_d     = ST_CONVERT;
      end
      ST_CONVERT: begin
        if (sts_i.conv_done) begin
          state_d = ST_PREP;
        end else begin
          cmd_o.conv_step = 1'b1;
        end
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = sts_i.neg ? ST_SIGN : ST_INT;
      end
      ST_SIGN: begin
        cmd_o.sel = SEL_SIGN;
        if (sts_i.slot_free) begin
          cmd_o.emit = 1'b1;
          state_d    = sts_i.last ? ST_IDLE : ST_INT;
        end
      end
      ST_INT: begin
        cmd_o.sel = SEL_INT;
        if (sts_i.slot_free) begin
          cmd_o.emit = 1'b1;
          priority if (sts_i.last) begin
            state_d = ST_IDLE;
          end else if (sts_i.ptr_zero) begin
            state_d = ST_DOT;
          end
        end
      end
      ST_DOT: begin
        cmd_o.sel = SEL_DOT;
        if (sts_i.slot_free) begin
          cmd_o.emit = 1'b1;
          state_d    = sts_i.last ? ST_IDLE : ST_FRAC;
        end
      end
      ST_FRAC: begin
        cmd_o.sel = SEL_FRAC;
        if (sts_i.slot_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.last) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/fixed_to_decimal_ascii_top.sv
// Top level of the fixed-point to decimal ASCII text formatter.
// Takes one signed fixed-point number (INT_BITS integer over FRAC_BITS fraction bits,
// in the low bits of the 64-bit input item) and streams its decimal text one ASCII
// character per output item, tlast on the final one: optional '-', the integer digits
// (a lone '0' for zero), then, if the rounded fraction is nonzero, '.' and the fraction
// digits with trailing zeros dropped. The fraction gets max(0, DIGIT_BUDGET - n) digits,
// at most 12, n being the smallest count with magnitude <= 10^n (n <= 10 at the default
// widths), and is rounded half up with carry into the integer. Text is capped at 22
// characters. One number is handled at a time: after an item is accepted, tready stays
// low through the search, scale, round, carry, convert, prep and emit steps, and longer
// under output stall. The binary-to-BCD conversion loop takes 40 steps; the digit-count
// search steps n up until it hits, and fraction scaling does one x10 per step.
// The last character sits in the output register while the next number is accepted.
`default_nettype none

module fixed_to_decimal_ascii_top import fda_pkg::*; #(
  parameter int INT_BITS     = 32,
  parameter int FRAC_BITS    = 32,
  parameter int DIGIT_BUDGET = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,   // [63:0] value
  // output stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [7:0] text_char
  output logic        m_axis_tlast_o    // last_char
);

  cmd_t cmd;
  sts_t sts;

  // sequencer: one item at a time through search, scale, round, convert, emit
  fda_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath holds the number, its BCD digits and the output register
  fda_datapath #(
    .INT_BITS     (INT_BITS),
    .FRAC_BITS    (FRAC_BITS),
    .DIGIT_BUDGET (DIGIT_BUDGET)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_value_i  (s_axis_tdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_char_o  (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o)
  );

endmodule

`default_nettype wire

// File: rtl/fda_checker.sv
// Port-level checker of the formatter, bound to the top level.
`default_nettype none

`include "fixed_to_decimal_ascii_top_assert.svh"

module fda_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_tvalid_i,
  input logic       s_tready_i,
  input logic       m_tvalid_i,
  input logic       m_tready_i,
  input logic [7:0] m_tdata_i,
  input logic       m_tlast_i
);

  `FDA_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_tvalid_i && !m_tready_i, m_tvalid_i && $stable(m_tdata_i) && $stable(m_tlast_i), "stalled output item changed")

  `FDA_ASSERT_NXT(a_one_at_a_time, clk_i, rst_ni, s_tvalid_i && s_tready_i, !s_tready_i, "input taken again right after an accept")

  `FDA_ASSERT_IMP(a_legal_char, clk_i, rst_ni, m_tvalid_i, (m_tdata_i == 8'h2D) || (m_tdata_i == 8'h2E) || ((m_tdata_i >= 8'h30) && (m_tdata_i <= 8'h39)), "illegal output character")

  `FDA_ASSERT_IMP(a_dot_not_last, clk_i, rst_ni, m_tvalid_i && ((m_tdata_i == 8'h2E) || (m_tdata_i == 8'h2D)), !m_tlast_i, "text ends in a sign or a point")

endmodule

bind fixed_to_decimal_ascii_top fda_checker u_fda_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tvalid_i (s_axis_tvalid_i),
  .s_tready_i (s_axis_tready_o),
  .m_tvalid_i (m_axis_tvalid_o),
  .m_tready_i (m_axis_tready_i),
  .m_tdata_i  (m_axis_tdata_o),
  .m_tlast_i  (m_axis_tlast_o)
);

`default_nettype wire
